@@ design/ppod_pkg.sv @@
package ppod_pkg;

    localparam int DATA_WIDTH   = 32;
    localparam int FRAC_BITS    = 16;
    localparam int ANG_FRAC     = 24;
    localparam int CORDIC_STEPS = 28;
    localparam int TRIG_FRAC    = 30;
    localparam int OUT_WIDTH    = DATA_WIDTH + 1;

    localparam int XY_W   = 33;
    localparam int Z_W    = 34;
    localparam int SUM_W  = 74;
    localparam int ROOT_W = SUM_W / 2;
    localparam int REM_W  = 40;

    localparam logic signed [XY_W-1:0] CORDIC_START = 33'sd652032874;
    localparam logic signed [34:0] ANG_HALF    = 35'sd3019898880;
    localparam logic signed [34:0] ANG_QUARTER = 35'sd1509949440;

    // reciprocal of 360 at 2^-24 and the offset that brings the sign-flip bias of the degree part to a multiple of 360
    localparam logic [15:0] RECIP_360  = 16'd46603;
    localparam logic [16:0] DEG_OFFSET = 17'd352;
    localparam logic [8:0]  DEG_FULL   = 9'd360;

    typedef struct packed {
        logic                         valid;
        logic signed [XY_W-1:0]       x;
        logic signed [XY_W-1:0]       y;
        logic signed [Z_W-1:0]        z;
        logic                         flip;
        logic signed [DATA_WIDTH-1:0] radius;
        logic signed [DATA_WIDTH-1:0] obs_x;
        logic signed [DATA_WIDTH-1:0] obs_y;
        logic signed [DATA_WIDTH-1:0] obs_z;
    } cordic_t;

    typedef struct packed {
        logic              valid;
        logic [REM_W-1:0]  rem;
        logic [ROOT_W-1:0] res;
        logic [SUM_W-1:0]  n;
    } root_t;

    function automatic logic signed [Z_W-1:0] atan_deg(input logic [4:0] idx);
        logic signed [Z_W-1:0] t;
        unique case (idx)
            5'd0:  t = 34'sd754974720;
            5'd1:  t = 34'sd445687602;
            5'd2:  t = 34'sd235489089;
            5'd3:  t = 34'sd119537938;
            5'd4:  t = 34'sd60000934;
            5'd5:  t = 34'sd30029717;
            5'd6:  t = 34'sd15018523;
            5'd7:  t = 34'sd7509720;
            5'd8:  t = 34'sd3754917;
            5'd9:  t = 34'sd1877466;
            5'd10: t = 34'sd938734;
            5'd11: t = 34'sd469367;
            5'd12: t = 34'sd234684;
            5'd13: t = 34'sd117342;
            5'd14: t = 34'sd58671;
            5'd15: t = 34'sd29335;
            5'd16: t = 34'sd14668;
            5'd17: t = 34'sd7334;
            5'd18: t = 34'sd3667;
            5'd19: t = 34'sd1833;
            5'd20: t = 34'sd917;
            5'd21: t = 34'sd458;
            5'd22: t = 34'sd229;
            5'd23: t = 34'sd115;
            5'd24: t = 34'sd57;
            5'd25: t = 34'sd29;
            5'd26: t = 34'sd14;
            5'd27: t = 34'sd7;
            default: t = '0;
        endcase
        return t;
    endfunction

endpackage

@@ design/ppod_cordic_cell.sv @@
module ppod_cordic_cell (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              en,
    input  logic [4:0]        step_idx,
    input  ppod_pkg::cordic_t cell_in,
    output ppod_pkg::cordic_t cell_out
);

    ppod_pkg::cordic_t cell_reg;
    ppod_pkg::cordic_t cell_next;

    always_comb begin
        logic signed [ppod_pkg::XY_W-1:0] sx;
        logic signed [ppod_pkg::XY_W-1:0] sy;
        logic signed [ppod_pkg::Z_W-1:0]  t;
        sx = cell_in.y >>> step_idx;
        sy = cell_in.x >>> step_idx;
        t  = ppod_pkg::atan_deg(step_idx);
        cell_next = cell_in;
        if (!cell_in.z[ppod_pkg::Z_W-1]) begin
            cell_next.x = cell_in.x - sx;
            cell_next.y = cell_in.y + sy;
            cell_next.z = cell_in.z - t;
        end else begin
            cell_next.x = cell_in.x + sx;
            cell_next.y = cell_in.y - sy;
            cell_next.z = cell_in.z + t;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cell_reg.valid <= 1'b0;
        end else if (en) begin
            cell_reg <= cell_next;
        end
    end

    assign cell_out = cell_reg;

endmodule

@@ design/ppod_root_cell.sv @@
module ppod_root_cell (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            en,
    input  ppod_pkg::root_t cell_in,
    output ppod_pkg::root_t cell_out
);

    ppod_pkg::root_t cell_reg;
    ppod_pkg::root_t cell_next;

    // one result bit per cell: bring down two radicand bits, trial subtract
    always_comb begin
        logic [ppod_pkg::REM_W-1:0] rem_sh;
        logic [ppod_pkg::REM_W-1:0] trial;
        rem_sh = {cell_in.rem[ppod_pkg::REM_W-3:0],
                  cell_in.n[ppod_pkg::SUM_W-1:ppod_pkg::SUM_W-2]};
        trial  = {1'b0, cell_in.res, 2'b01};
        cell_next       = cell_in;
        cell_next.n     = {cell_in.n[ppod_pkg::SUM_W-3:0], 2'b00};
        if (rem_sh >= trial) begin
            cell_next.rem = rem_sh - trial;
            cell_next.res = {cell_in.res[ppod_pkg::ROOT_W-2:0], 1'b1};
        end else begin
            cell_next.rem = rem_sh;
            cell_next.res = {cell_in.res[ppod_pkg::ROOT_W-2:0], 1'b0};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cell_reg.valid <= 1'b0;
        end else if (en) begin
            cell_reg <= cell_next;
        end
    end

    assign cell_out = cell_reg;

endmodule

@@ design/polar_point_observer_distance_unit.sv @@
// channel   ports                                          direction
// input     s_valid s_ready s_radius s_azimuth_deg         in
//           s_obs_x s_obs_y s_obs_z
// result    m_valid m_ready m_distance                     out
//
// one transfer per cycle in and out while the pipeline is not held; stages: 2 angle reduction,
// 28 cordic cells, 4 multiply/square/sum, 37 root cells, 1 output register
// the whole pipeline advances together; it holds when the output register
// is full and m_ready is low, and s_ready follows that same enable
// reset clears only the valid bits of the pipeline
module polar_point_observer_distance_unit (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 s_valid,
    output logic                                 s_ready,
    input  logic signed [ppod_pkg::DATA_WIDTH-1:0] s_radius,
    input  logic signed [ppod_pkg::DATA_WIDTH-1:0] s_azimuth_deg,
    input  logic signed [ppod_pkg::DATA_WIDTH-1:0] s_obs_x,
    input  logic signed [ppod_pkg::DATA_WIDTH-1:0] s_obs_y,
    input  logic signed [ppod_pkg::DATA_WIDTH-1:0] s_obs_z,
    output logic                                 m_valid,
    input  logic                                 m_ready,
    output logic [ppod_pkg::OUT_WIDTH-1:0]       m_distance
);

    localparam int DW = ppod_pkg::DATA_WIDTH;
    localparam int NC = ppod_pkg::CORDIC_STEPS;
    localparam int NR = ppod_pkg::ROOT_W;

    logic en;

    // stage a: degree part quotient estimate
    logic                 a_valid_reg;
    logic [16:0]          a_v_reg;
    logic [7:0]           a_q_reg;
    logic [15:0]          a_lo_reg;
    logic signed [DW-1:0] a_rad_reg, a_ox_reg, a_oy_reg, a_oz_reg;

    logic [16:0] a_v_next;
    logic [32:0] a_prod;

    assign a_v_next = {~s_azimuth_deg[DW-1], s_azimuth_deg[DW-2:16]} + ppod_pkg::DEG_OFFSET;
    assign a_prod   = a_v_next * ppod_pkg::RECIP_360;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_valid_reg <= 1'b0;
        end else if (en) begin
            a_valid_reg <= s_valid;
            a_v_reg     <= a_v_next;
            a_q_reg     <= a_prod[31:24];
            a_lo_reg    <= s_azimuth_deg[15:0];
            a_rad_reg   <= s_radius;
            a_ox_reg    <= s_obs_x;
            a_oy_reg    <= s_obs_y;
            a_oz_reg    <= s_obs_z;
        end
    end

    // stage b: remainder, fold to [-90, 90] and seed the cordic chain
    ppod_pkg::cordic_t chain [NC+1];
    ppod_pkg::cordic_t b_reg;
    ppod_pkg::cordic_t b_next;

    always_comb begin
        logic [16:0]       r;
        logic [24:0]       red;
        logic signed [34:0] z;
        r   = a_v_reg - 17'(a_q_reg) * 17'(ppod_pkg::DEG_FULL);
        if (r >= 17'(ppod_pkg::DEG_FULL)) begin
            r = r - 17'(ppod_pkg::DEG_FULL);
        end
        red = {r[8:0], a_lo_reg};
        z   = 35'({red, 8'd0});
        if (z > ppod_pkg::ANG_HALF) begin
            z = z - (ppod_pkg::ANG_HALF <<< 1);
        end
        b_next.flip = 1'b0;
        if (z > ppod_pkg::ANG_QUARTER) begin
            z = z - ppod_pkg::ANG_HALF;
            b_next.flip = 1'b1;
        end else if (z < -ppod_pkg::ANG_QUARTER) begin
            z = z + ppod_pkg::ANG_HALF;
            b_next.flip = 1'b1;
        end
        b_next.valid  = a_valid_reg;
        b_next.x      = ppod_pkg::CORDIC_START;
        b_next.y      = '0;
        b_next.z      = z[ppod_pkg::Z_W-1:0];
        b_next.radius = a_rad_reg;
        b_next.obs_x  = a_ox_reg;
        b_next.obs_y  = a_oy_reg;
        b_next.obs_z  = a_oz_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            b_reg.valid <= 1'b0;
        end else if (en) begin
            b_reg <= b_next;
        end
    end

    assign chain[0] = b_reg;

    for (genvar i = 0; i < NC; i++) begin : g_cordic
        ppod_cordic_cell u_cell (
            .aclk     (aclk),
            .aresetn  (aresetn),
            .en       (en),
            .step_idx (5'(i)),
            .cell_in  (chain[i]),
            .cell_out (chain[i+1])
        );
    end

    // m1: scale by radius and undo the fold's sign flip
    logic                 m1_valid_reg;
    logic signed [34:0]   m1_px_reg, m1_py_reg;
    logic signed [DW-1:0] m1_ox_reg, m1_oy_reg, m1_oz_reg;

    logic signed [64:0] px_prod, py_prod, px_fix, py_fix;
    assign px_prod = chain[NC].radius * chain[NC].x;
    assign py_prod = chain[NC].radius * chain[NC].y;
    assign px_fix  = chain[NC].flip ? -px_prod : px_prod;
    assign py_fix  = chain[NC].flip ? -py_prod : py_prod;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m1_valid_reg <= 1'b0;
        end else if (en) begin
            m1_valid_reg <= chain[NC].valid;
            m1_px_reg    <= px_fix[64:30];
            m1_py_reg    <= py_fix[64:30];
            m1_ox_reg    <= chain[NC].obs_x;
            m1_oy_reg    <= chain[NC].obs_y;
            m1_oz_reg    <= chain[NC].obs_z;
        end
    end

    // m2: differences and magnitudes
    logic               m2_valid_reg;
    logic [35:0]        m2_dx_reg, m2_dy_reg;
    logic [DW-1:0]      m2_oz_reg;
    logic signed [35:0] dx, dy;

    assign dx = 36'(m1_px_reg) - 36'(m1_ox_reg);
    assign dy = 36'(m1_py_reg) - 36'(m1_oy_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m2_valid_reg <= 1'b0;
        end else if (en) begin
            m2_valid_reg <= m1_valid_reg;
            m2_dx_reg    <= dx[35] ? 36'(-dx) : 36'(dx);
            m2_dy_reg    <= dy[35] ? 36'(-dy) : 36'(dy);
            m2_oz_reg    <= m1_oz_reg[DW-1] ? DW'(-m1_oz_reg) : DW'(m1_oz_reg);
        end
    end

    // m3: squares
    logic        m3_valid_reg;
    logic [71:0] m3_sx_reg, m3_sy_reg;
    logic [63:0] m3_sz_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m3_valid_reg <= 1'b0;
        end else if (en) begin
            m3_valid_reg <= m2_valid_reg;
            m3_sx_reg    <= m2_dx_reg * m2_dx_reg;
            m3_sy_reg    <= m2_dy_reg * m2_dy_reg;
            m3_sz_reg    <= m2_oz_reg * m2_oz_reg;
        end
    end

    // m4: sum into the root chain
    ppod_pkg::root_t rchain [NR+1];
    ppod_pkg::root_t m4_reg;
    ppod_pkg::root_t m4_next;

    always_comb begin
        m4_next.valid = m3_valid_reg;
        m4_next.rem   = '0;
        m4_next.res   = '0;
        m4_next.n     = ppod_pkg::SUM_W'(m3_sx_reg) + ppod_pkg::SUM_W'(m3_sy_reg)
                      + ppod_pkg::SUM_W'(m3_sz_reg);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m4_reg.valid <= 1'b0;
        end else if (en) begin
            m4_reg <= m4_next;
        end
    end

    assign rchain[0] = m4_reg;

    for (genvar j = 0; j < NR; j++) begin : g_root
        ppod_root_cell u_cell (
            .aclk     (aclk),
            .aresetn  (aresetn),
            .en       (en),
            .cell_in  (rchain[j]),
            .cell_out (rchain[j+1])
        );
    end

    // output register with saturation
    logic                          out_valid_reg;
    logic [ppod_pkg::OUT_WIDTH-1:0] out_dist_reg;
    logic [ppod_pkg::OUT_WIDTH-1:0] out_dist_next;

    assign out_dist_next = (|rchain[NR].res[NR-1:ppod_pkg::OUT_WIDTH])
                         ? '1 : rchain[NR].res[ppod_pkg::OUT_WIDTH-1:0];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (en) begin
            out_valid_reg <= rchain[NR].valid;
            out_dist_reg  <= out_dist_next;
        end
    end

    assign en         = !out_valid_reg || m_ready;
    assign s_ready    = en;
    assign m_valid    = out_valid_reg;
    assign m_distance = out_dist_reg;

endmodule

@@ verif/polar_point_observer_distance_unit_tb.sv @@
module polar_point_observer_distance_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int LATENCY = 72;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_valid = 1'b0;
    logic s_ready;
    logic signed [ppod_pkg::DATA_WIDTH-1:0] s_radius = '0;
    logic signed [ppod_pkg::DATA_WIDTH-1:0] s_azimuth_deg = '0;
    logic signed [ppod_pkg::DATA_WIDTH-1:0] s_obs_x = '0;
    logic signed [ppod_pkg::DATA_WIDTH-1:0] s_obs_y = '0;
    logic signed [ppod_pkg::DATA_WIDTH-1:0] s_obs_z = '0;
    logic m_valid;
    logic m_ready = 1'b0;
    logic [ppod_pkg::OUT_WIDTH-1:0] m_distance;

    logic [ppod_pkg::OUT_WIDTH-1:0] expected_dist_q[$];
    int error_count = 0;
    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    int hold_off_cycles = 0;

    polar_point_observer_distance_unit DUT (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready),
        .s_radius(s_radius), .s_azimuth_deg(s_azimuth_deg),
        .s_obs_x(s_obs_x), .s_obs_y(s_obs_y), .s_obs_z(s_obs_z),
        .m_valid(m_valid), .m_ready(m_ready), .m_distance(m_distance)
    );

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    function automatic longint floor_shr(longint v, int s);
        return v >>> s;
    endfunction

    function automatic logic [ppod_pkg::OUT_WIDTH-1:0] observer_distance(
        longint radius, longint ang, longint ox, longint oy, longint oz);
        longint atan_tab[ppod_pkg::CORDIC_STEPS] = '{
            754974720, 445687602, 235489089, 119537938, 60000934, 30029717,
            15018523, 7509720, 3754917, 1877466, 938734, 469367, 234684,
            117342, 58671, 29335, 14668, 7334, 3667, 1833, 917, 458, 229,
            115, 57, 29, 14, 7};
        longint full, half, quarter, red, z, cx, cy, sx, sy, px, py, dx, dy;
        logic [127:0] sum;
        logic [127:0] cand;
        logic [63:0] root;
        logic flip;
        logic signed [127:0] prod;
        full = longint'(360) << ppod_pkg::FRAC_BITS;
        half = longint'(180) << ppod_pkg::ANG_FRAC;
        quarter = longint'(90) << ppod_pkg::ANG_FRAC;
        flip = 1'b0;
        red = ang % full;
        if (red < 0) red += full;
        z = red << (ppod_pkg::ANG_FRAC - ppod_pkg::FRAC_BITS);
        if (z > half) z -= 2 * half;
        if (z > quarter) begin
            z -= half;
            flip = 1'b1;
        end else if (z < -quarter) begin
            z += half;
            flip = 1'b1;
        end
        cx = 652032874;
        cy = 0;
        for (int i = 0; i < ppod_pkg::CORDIC_STEPS; i++) begin
            sx = floor_shr(cy, i);
            sy = floor_shr(cx, i);
            if (z >= 0) begin
                cx -= sx; cy += sy; z -= atan_tab[i];
            end else begin
                cx += sx; cy -= sy; z += atan_tab[i];
            end
        end
        if (flip) begin
            cx = -cx; cy = -cy;
        end
        prod = 128'(radius) * 128'(cx);
        px = longint'(prod >>> ppod_pkg::TRIG_FRAC);
        prod = 128'(radius) * 128'(cy);
        py = longint'(prod >>> ppod_pkg::TRIG_FRAC);
        dx = px - ox;
        dy = py - oy;
        // squares at full width, a difference can reach 2^32
        sum = 128'(dx) * 128'(dx) + 128'(dy) * 128'(dy) + 128'(oz) * 128'(oz);
        root = '0;
        for (int b = 63; b >= 0; b--) begin
            cand = 128'(root | (64'd1 << b));
            if (cand * cand <= sum) root = cand[63:0];
        end
        if (root > 64'h1_FFFF_FFFF) root = 64'h1_FFFF_FFFF;
        return root[ppod_pkg::OUT_WIDTH-1:0];
    endfunction

    task automatic send_point(logic [31:0] r, logic [31:0] a, logic [31:0] x,
                              logic [31:0] y, logic [31:0] z);
        while (send_idle_pct > 0 && $urandom_range(99, 0) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_radius <= r;
        s_azimuth_deg <= a;
        s_obs_x <= x;
        s_obs_y <= y;
        s_obs_z <= z;
        expected_dist_q.push_back(observer_distance(longint'($signed(r)),
            longint'($signed(a)), longint'($signed(x)), longint'($signed(y)),
            longint'($signed(z))));
        do @(posedge aclk); while (!s_ready);
        @(negedge aclk);
    endtask

    // receiver: random stalls, plus a counted hold-off on request
    always @(negedge aclk) begin
        if (hold_off_cycles > 0) begin
            m_ready <= 1'b0;
            hold_off_cycles <= hold_off_cycles - 1;
        end else begin
            m_ready <= !(recv_stall_pct > 0 && $urandom_range(99, 0) < recv_stall_pct);
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (expected_dist_q.size() == 0) begin
                $display("%0t: unexpected transfer, distance %h", $time, m_distance);
                error_count++;
            end else begin
                if (m_distance !== expected_dist_q[0]) begin
                    $display("%0t: distance expected %h actual %h", $time,
                             expected_dist_q[0], m_distance);
                    error_count++;
                end
                void'(expected_dist_q.pop_front());
            end
        end
    end

    function automatic logic [31:0] edge_value(int k);
        case (k % 6)
            0: return 32'h8000_0000;
            1: return 32'h7FFF_FFFF;
            2: return 32'h0000_0000;
            3: return 32'hFFFF_FFFF;
            4: return 32'h0001_0000;
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [31:0] random_field();
        case ($urandom_range(3, 0))
            0: return $urandom;
            1: return 32'($signed($urandom_range(2000, 0)) - 1000) << 16;
            2: return $urandom_range(32'h00FF_FFFF, 0) - 32'h0080_0000;
            default: return edge_value($urandom_range(5, 0));
        endcase
    endfunction

    function automatic logic [31:0] random_angle();
        case ($urandom_range(3, 0))
            0: return $urandom;
            1: return 32'($signed($urandom_range(8, 0)) * 90 - 360) << 16;
            default: return 32'($signed($urandom_range(1440, 0)) - 720) << 16;
        endcase
    endfunction

    task automatic wait_drained();
        s_valid <= 1'b0;
        while (expected_dist_q.size() != 0) @(negedge aclk);
    endtask

    task automatic test_directed();
        int angles[10] = '{0, 90, 180, 270, 360, -90, -180, 45, 720, -1};
        for (int i = 0; i < 10; i++)
            send_point(32'h0010_0000, 32'(angles[i]) << 16, 0, 0, 0);
        send_point(32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                   32'h8000_0000);
        send_point(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000,
                   32'h7FFF_FFFF);
        send_point(32'hFFF0_0000, 32'h001E_0000, 32'h0001_0000, 32'hFFFF_0000,
                   32'h0002_0000);
        send_point(0, 0, 0, 0, 0);
        send_point(32'hFFFF_FFFF, 32'h00B4_0000, 32'h0000_0001, 32'hFFFF_FFFF, 1);
        for (int i = 0; i < 8; i++)
            send_point(edge_value(i), edge_value(i + 1), edge_value(i + 2),
                       edge_value(i + 3), edge_value(i + 4));
    endtask

    task automatic test_random(int count);
        for (int i = 0; i < count; i++)
            send_point(random_field(), random_angle(), random_field(),
                       random_field(), random_field());
    endtask

    task automatic test_backpressure();
        hold_off_cycles = 300;
        test_random(150);
        wait_drained();
        send_idle_pct = 0;
        repeat (20) @(negedge aclk);
        test_random(50);
    endtask

    initial begin
        repeat (11) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;
        test_directed();
        test_random(400);
        send_idle_pct = 71;
        test_random(400);
        send_idle_pct = 0;
        recv_stall_pct = 71;
        test_random(400);
        send_idle_pct = 19;
        recv_stall_pct = 19;
        test_random(400);
        send_idle_pct = 0;
        recv_stall_pct = 0;
        test_backpressure();
        wait_drained();
        repeat (LATENCY + 10) @(negedge aclk);
        if (error_count == 0 && expected_dist_q.size() == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

    initial begin
        #2ms;
        $display("Regression FAIL");
        $finish;
    end
endmodule

@@ filelist.f @@
design/ppod_pkg.sv
design/ppod_cordic_cell.sv
design/ppod_root_cell.sv
design/polar_point_observer_distance_unit.sv
verif/polar_point_observer_distance_unit_tb.sv
